>>> src/lpfr_pkg.sv
package lpfr_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } lpfr_state_t;

  // bits for a frame index or a recency rank, never below one
  function automatic int idx_bits(int frames);
    int w;
    w = $clog2(frames);
    return (w < 1) ? 1 : w;
  endfunction

endpackage

>>> src/lpfr_cell.sv
module lpfr_cell import lpfr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic active,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [5*idx_bits(FRAMES)+PAGE_BITS+3-1:0] tok_i,
  output logic [5*idx_bits(FRAMES)+PAGE_BITS+3-1:0] tok_o,
  input  logic [idx_bits(FRAMES)*2+PAGE_BITS+2-1:0] upd
);

  localparam int RW = idx_bits(FRAMES);
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);
  localparam logic [RW-1:0] MY_IDX   = RW'(IDX);

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [RW-1:0]        hit_idx;
    logic [RW-1:0]        hit_rank;
    logic                 free;
    logic [RW-1:0]        free_idx;
    logic [RW-1:0]        max_rank;
    logic [RW-1:0]        max_idx;
    logic [PAGE_BITS-1:0] max_page;
  } tok_t;

  typedef struct packed {
    logic                 en;
    logic [RW-1:0]        idx;
    logic                 f_valid;
    logic [RW-1:0]        rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  tok_t tin, tok_r, tok_nxt;
  upd_t u;

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic [RW-1:0]        rank_r, rank_nxt;

  assign tin   = tok_t'(tok_i);
  assign u     = upd_t'(upd);
  assign tok_o = tok_r;

  // fold this frame into the passing search token
  always_comb begin
    tok_nxt = tin;
    if (active && tin.valid) begin
      if (!tin.hit && valid_r && (page_r == page)) begin
        tok_nxt.hit      = 1'b1;
        tok_nxt.hit_idx  = MY_IDX;
        tok_nxt.hit_rank = rank_r;
      end
      if (!tin.free && !valid_r) begin
        tok_nxt.free     = 1'b1;
        tok_nxt.free_idx = MY_IDX;
      end
      if ((IDX == 0) || (rank_r > tin.max_rank)) begin
        tok_nxt.max_rank = rank_r;
        tok_nxt.max_idx  = MY_IDX;
        tok_nxt.max_page = page_r;
      end
    end
  end

  // load the chosen frame, age the younger ones (every valid one when the chosen frame was free)
  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (u.en && active) begin
      if (u.idx == MY_IDX) begin
        page_nxt  = u.page;
        valid_nxt = 1'b1;
        rank_nxt  = '0;
      end else if (valid_r && (!u.f_valid || (rank_r < u.rank)) && (rank_r != RANK_MAX)) begin
        rank_nxt = rank_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      page_r  <= '0;
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      tok_r   <= tok_nxt;
      page_r  <= page_nxt;
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

endmodule

>>> src/lru_page_frame_replacer_top.sv
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+-------------------------------
// request   | in_page_number                          | start high, busy low at edge
// result    | out_fault, out_frame_index,             | out_strobe high for one cycle
//           | out_evicted_valid, out_evicted_page,    |
//           | out_fault_count                         |
// config    | cfg_we, cfg_data (frames_in_use)        | written at edge with cfg_we
//
// a request's result strobe follows its accept once the token has passed every frame
// cell register; busy falls together with the strobe, so the next request is taken
// at the edge that ends the strobe cycle, and no new request is taken while one is
// in flight; the search token walks the frame cells one per cycle
// synchronous active-low reset frees every frame and clears the fault count
// the result receiver cannot stall: each result is shown for exactly one cycle
module lru_page_frame_replacer_top import lpfr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_page_number,
  output logic        out_strobe,
  output logic        out_fault,
  output logic [3:0]  out_frame_index,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [15:0] out_fault_count,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);

  localparam int RW    = idx_bits(FRAMES);
  localparam int TOK_W = 5 * RW + PAGE_BITS + 3;
  localparam int UPD_W = 2 * RW + PAGE_BITS + 2;

  // search token, walks from frame 0 toward the last frame
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [RW-1:0]        hit_idx;
    logic [RW-1:0]        hit_rank;
    logic                 free;
    logic [RW-1:0]        free_idx;
    logic [RW-1:0]        max_rank;
    logic [RW-1:0]        max_idx;
    logic [PAGE_BITS-1:0] max_page;
  } tok_t;

  // broadcast update to every cell once the token is back
  typedef struct packed {
    logic                 en;
    logic [RW-1:0]        idx;
    logic                 f_valid;
    logic [RW-1:0]        rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  lpfr_state_t state_r, state_nxt;

  logic [4:0]           cfg_r, cfg_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 go_r, go_nxt;
  logic [15:0]          faults_r, faults_nxt;

  logic        strobe_r, strobe_nxt;
  logic        fault_r, fault_nxt;
  logic [3:0]  index_r, index_nxt;
  logic        ev_valid_r, ev_valid_nxt;
  logic [15:0] ev_page_r, ev_page_nxt;

  logic              accept;
  logic              done;
  logic [4:0]        n_act;
  logic [FRAMES-1:0] active;
  tok_t              seed, last;
  upd_t              upd;
  logic [RW-1:0]     f_idx;

  logic [TOK_W-1:0] tok_w [FRAMES+1];

  // ---------------------------------------------------------------------------
  // control fsm
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SEARCH;
      ST_SEARCH: if (done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_SEARCH: busy = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // active frame count, zero acts as one, capped at the built count
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cfg_r == 5'd0) begin
      n_act = 5'd1;
    end else if (int'(cfg_r) > FRAMES) begin
      n_act = 5'(FRAMES);
    end else begin
      n_act = cfg_r;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i < int'(n_act));
    end
  end

  // ---------------------------------------------------------------------------
  // request capture and token seed
  // ---------------------------------------------------------------------------
  assign cfg_nxt  = cfg_we ? cfg_data : cfg_r;
  assign page_nxt = accept ? PAGE_BITS'(in_page_number) : page_r;
  assign go_nxt   = accept;

  always_comb begin
    seed       = '0;
    seed.valid = go_r;
  end

  assign tok_w[0] = seed;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      lpfr_cell #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX       (g)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (active[g]),
        .page   (page_r),
        .tok_i  (tok_w[g]),
        .tok_o  (tok_w[g+1]),
        .upd    (UPD_W'(upd))
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // decision once the token leaves the last cell
  // ---------------------------------------------------------------------------
  assign last = tok_t'(tok_w[FRAMES]);
  assign done = last.valid;

  always_comb begin
    if (last.hit) begin
      f_idx = last.hit_idx;
    end else if (last.free) begin
      f_idx = last.free_idx;
    end else begin
      f_idx = last.max_idx;
    end
  end

  always_comb begin
    upd.en      = done;
    upd.idx     = f_idx;
    upd.page    = page_r;
    // a free frame ages every valid frame, otherwise only the younger ones
    upd.f_valid = last.hit || !last.free;
    upd.rank    = last.hit ? last.hit_rank : last.max_rank;
  end

  // fault counter saturates at all ones
  always_comb begin
    faults_nxt = faults_r;
    if (done && !last.hit && (faults_r != 16'hFFFF)) begin
      faults_nxt = faults_r + 16'd1;
    end
  end

  always_comb begin
    strobe_nxt   = done;
    fault_nxt    = fault_r;
    index_nxt    = index_r;
    ev_valid_nxt = ev_valid_r;
    ev_page_nxt  = ev_page_r;
    if (done) begin
      fault_nxt    = !last.hit;
      index_nxt    = 4'(f_idx);
      ev_valid_nxt = !last.hit && !last.free;
      ev_page_nxt  = (!last.hit && !last.free) ? 16'(last.max_page) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cfg_r    <= 5'd16;
      go_r     <= 1'b0;
      faults_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cfg_r    <= cfg_nxt;
      go_r     <= go_nxt;
      faults_r <= faults_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    fault_r    <= fault_nxt;
    index_r    <= index_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_fault         = fault_r;
  assign out_frame_index   = index_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_count   = faults_r;

endmodule

>>> src/lpfr_checker.sv
module lpfr_checker import lpfr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_fault,
  input logic        out_evicted_valid,
  input logic [15:0] out_evicted_page
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy did not rise");

  a_accept_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("result strobe right after request accept");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_fault) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_evicted_valid) |-> (out_evicted_page == 16'd0))
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_frame_replacer_top lpfr_checker u_lpfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_fault         (out_fault),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAMES = 16;
  localparam int LATENCY = FRAMES + 1;
  localparam int GAP_PERCENT = 18;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;

  // one result of the replacer, field for field
  typedef struct packed {
    logic        fault;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] fault_count;
  } replace_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_page_number;
  logic        out_strobe;
  logic        out_fault;
  logic [3:0]  out_frame_index;
  logic        out_evicted_valid;
  logic [15:0] out_evicted_page;
  logic [15:0] out_fault_count;
  logic        cfg_we;
  logic [4:0]  cfg_data;

  // predicted frame table: page, valid mark and recency rank per frame
  logic [15:0] frame_page_q [FRAMES];
  bit          frame_valid_q [FRAMES];
  int          frame_rank_q [FRAMES];
  logic [15:0] fault_total;
  logic [4:0]  frames_setting;

  // results still owed by the block, oldest first
  replace_result_t owed_results[$];

  int          mismatch_count;
  bit          gaps_on;
  logic [15:0] last_page;

  lru_page_frame_replacer_top #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(16)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .out_strobe       (out_strobe),
    .out_fault        (out_fault),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // state right after reset: every frame free, count clear, all frames on
  task automatic clear_frame_table();
    for (int i = 0; i < FRAMES; i++) begin
      frame_page_q[i]  = '0;
      frame_valid_q[i] = 1'b0;
      frame_rank_q[i]  = 0;
    end
    fault_total    = '0;
    frames_setting = 5'd16;
  endtask

  // looks the page up, replaces on a miss and returns what the block must report
  function automatic replace_result_t lookup_and_replace(input logic [15:0] page);
    int              n;
    int              f;
    int              rank_limit;
    bit              hit;
    bit              found_free;
    replace_result_t r;
    // setting of zero acts as one frame, anything above the build acts as all
    n = int'(frames_setting);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    hit = 1'b0;
    found_free = 1'b0;
    f = 0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (!hit && frame_valid_q[i] && frame_page_q[i] == page) begin
        hit = 1'b1;
        f = i;
      end
    end
    if (!hit) begin
      if (fault_total != COUNT_FULL) fault_total = fault_total + 16'd1;
      for (int i = 0; i < n; i++) begin
        if (!found_free && !frame_valid_q[i]) begin
          found_free = 1'b1;
          f = i;
        end
      end
      // no free frame: oldest rank loses, lowest frame number on a tie
      if (!found_free) begin
        f = 0;
        for (int i = 1; i < n; i++) begin
          if (frame_rank_q[i] > frame_rank_q[f]) f = i;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page_q[f];
      end
    end
    // age frames younger than f (every valid frame when f was free), ranks stop at FRAMES-1
    rank_limit = frame_valid_q[f] ? frame_rank_q[f] : FRAMES;
    for (int i = 0; i < n; i++) begin
      if (i != f && frame_valid_q[i] && frame_rank_q[i] < rank_limit &&
          frame_rank_q[i] < FRAMES - 1)
        frame_rank_q[i]++;
    end
    frame_rank_q[f]  = 0;
    frame_page_q[f]  = page;
    frame_valid_q[f] = 1'b1;
    r.fault       = !hit;
    r.frame_index = f[3:0];
    r.fault_count = fault_total;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // results are shown for one cycle only, so every strobe is taken
  always @(posedge clk) begin
    replace_result_t want;
    if (rst_n && out_strobe) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with no request", out_frame_index, 0);
      end else begin
        want = owed_results.pop_front();
        if (out_fault !== want.fault)
          report_mismatch("fault", out_fault, want.fault);
        if (out_frame_index !== want.frame_index)
          report_mismatch("frame_index", out_frame_index, want.frame_index);
        if (out_evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", out_evicted_valid, want.evicted_valid);
        if (out_evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", out_evicted_page, want.evicted_page);
        if (out_fault_count !== want.fault_count)
          report_mismatch("fault_count", out_fault_count, want.fault_count);
      end
    end
  end

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------

  // one page reference; start is left high so a back-to-back request
  // simply replaces the page at the next falling edge
  task automatic issue_reference(input logic [15:0] page);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      // gap length spread over the whole busy window and past it
      start = 1'b0;
      repeat ($urandom_range(1, 2 * LATENCY)) @(negedge clk);
    end
    in_page_number = page;
    start = 1'b1;
    do @(posedge clk); while (busy);
    owed_results.push_back(lookup_and_replace(page));
    last_page = page;
  endtask

  // stop requesting and hold off until the block has delivered everything
  task automatic drain_requests();
    @(negedge clk);
    start = 1'b0;
    while (owed_results.size() != 0 || busy) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_frame_count(input logic [4:0] value);
    drain_requests();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    frames_setting = value;
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // page zero must miss after reset even though the frames hold zero
  task automatic test_reset_defaults();
    issue_reference(16'h0000);
    issue_reference(16'hFFFF);
    issue_reference(16'h0000);
  endtask

  // a setting of zero behaves as a single frame
  task automatic test_frame_count_floor();
    write_frame_count(5'd0);
    issue_reference(16'h1234);
    issue_reference(16'h1234);
    issue_reference(16'h8001);
  endtask

  // a setting above the build behaves as every frame
  task automatic test_frame_count_ceiling();
    write_frame_count(5'd31);
    issue_reference(16'hFFFF);
    issue_reference(16'h5A5A);
  endtask

  // shrinking hides upper frames, growing brings their stale pages and ranks back
  task automatic test_frame_count_change();
    write_frame_count(5'd2);
    issue_reference(16'h0F0F);
    issue_reference(16'hF0F0);
    issue_reference(16'h0F0F);
    issue_reference(16'h3C3C);
    write_frame_count(5'd16);
    issue_reference(16'h5A5A);
    issue_reference(16'hC3C3);
    issue_reference(16'h0000);
  endtask

  // phases of random references over a working set sized near the frame count
  task automatic test_random_traffic();
    logic [15:0] page_pool [24];
    logic [4:0]  settings [8];
    int          pool_size;
    int          active;
    int          pick;
    logic [15:0] page;
    settings = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'd0, 5'd0};
    settings[6] = 5'($urandom_range(0, 31));
    settings[7] = 5'($urandom_range(2, 15));
    for (int phase = 0; phase < 8; phase++) begin
      write_frame_count(settings[phase]);
      active = int'(settings[phase]);
      if (active < 1) active = 1;
      if (active > FRAMES) active = FRAMES;
      pool_size = active + $urandom_range(1, 6);
      if (pool_size > 24) pool_size = 24;
      for (int i = 0; i < 24; i++) page_pool[i] = 16'($urandom);
      // one phase runs with no sender gaps at all
      gaps_on = (phase != 2);
      for (int k = 0; k < 100; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) page = page_pool[$urandom_range(0, pool_size - 1)];
        else if (pick < 80) page = last_page;
        else page = 16'($urandom);
        issue_reference(page);
      end
    end
    gaps_on = 1'b1;
  endtask

  // single frame with a fresh page each time: every request faults and
  // evicts the page before it, then a repeat of the last page hits
  task automatic test_single_frame_churn();
    logic [15:0] page;
    write_frame_count(5'd1);
    gaps_on = 1'b0;
    page = 16'($urandom);
    repeat (24) begin
      page = page ^ 16'($urandom_range(1, 65535));
      issue_reference(page);
    end
    issue_reference(page);
    gaps_on = 1'b1;
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    last_page      = '0;
    clear_frame_table();
    // reset once, released away from the rising edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_frame_count_floor();
    test_frame_count_ceiling();
    test_frame_count_change();
    test_random_traffic();
    test_single_frame_churn();

    // everything owed must arrive, then nothing more may show up
    drain_requests();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lpfr_pkg.sv
src/lpfr_cell.sv
src/lru_page_frame_replacer_top.sv
src/lpfr_checker.sv
tb/sv/testbench.sv
